// ----- rtl/stl_pkg.sv -----
`default_nettype none
package stl_pkg;

   localparam int DEF_OFFSET_BITS = 24;
   localparam int DEF_LENGTH_BITS = 16;
   localparam int LINE_BITS       = 24;
   localparam int QUEUE_DEPTH     = 4;
   localparam int PTR_BITS        = $clog2(QUEUE_DEPTH);

   localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

   localparam logic [5:0] KIND_END    = 6'd0;
   localparam logic [5:0] KIND_ERROR  = 6'd1;
   localparam logic [5:0] KIND_IDENT  = 6'd2;
   localparam logic [5:0] KIND_NUMBER = 6'd3;
   localparam logic [5:0] KIND_STRING = 6'd4;
   localparam logic [5:0] KIND_CHAR   = 6'd5;
   localparam logic [5:0] KIND_PLUS   = 6'd6;
   localparam logic [5:0] KIND_MINUS  = 6'd7;
   localparam logic [5:0] KIND_STAR   = 6'd8;
   localparam logic [5:0] KIND_SLASH  = 6'd9;
   localparam logic [5:0] KIND_LPAREN = 6'd10;
   localparam logic [5:0] KIND_RPAREN = 6'd11;
   localparam logic [5:0] KIND_ASSIGN = 6'd12;
   localparam logic [5:0] KIND_SEMI   = 6'd13;
   localparam logic [5:0] KIND_LBRACE = 6'd14;
   localparam logic [5:0] KIND_RBRACE = 6'd15;
   localparam logic [5:0] KIND_COMMA  = 6'd16;
   localparam logic [5:0] KIND_AMP    = 6'd17;
   localparam logic [5:0] KIND_DOT    = 6'd18;
   localparam logic [5:0] KIND_LBRACK = 6'd19;
   localparam logic [5:0] KIND_RBRACK = 6'd20;
   localparam logic [5:0] KIND_BANG   = 6'd21;
   localparam logic [5:0] KW_IF       = 6'd22;
   localparam logic [5:0] KW_I32      = 6'd23;
   localparam logic [5:0] KW_I64      = 6'd24;
   localparam logic [5:0] KW_FALSE    = 6'd25;
   localparam logic [5:0] KW_F32      = 6'd26;
   localparam logic [5:0] KW_F64      = 6'd27;
   localparam logic [5:0] KW_FOR      = 6'd28;
   localparam logic [5:0] KW_TRUE     = 6'd29;
   localparam logic [5:0] KW_PRINT    = 6'd30;
   localparam logic [5:0] KW_ELSE     = 6'd31;
   localparam logic [5:0] KW_BOOL     = 6'd32;
   localparam logic [5:0] KW_STRUCT   = 6'd33;
   localparam logic [5:0] KW_SIZEOF   = 6'd34;
   localparam logic [5:0] KW_VOID     = 6'd35;
   localparam logic [5:0] KW_CHAR     = 6'd36;
   localparam logic [5:0] KW_WHILE    = 6'd37;
   localparam logic [5:0] KW_RETURN   = 6'd38;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_IDENT, MODE_INT, MODE_INT_DOT, MODE_FRAC, MODE_MINUS,
      MODE_SLASH, MODE_LINE, MODE_BLOCK, MODE_STAR, MODE_STRING,
      MODE_CH_OPEN, MODE_CH_ESC, MODE_CH_CLOSE
   } scan_mode_type;

   typedef struct packed {
      logic            push;
      logic [1:0]      count;
      logic [2:0][5:0] kind;
   } tok_ctl_type;

   // Keyword lookup on the last n identifier bytes; n of zero means too long.
   function automatic logic [5:0] ident_kind(input logic [47:0] p, input logic [2:0] n);
      logic [5:0] k;
      k = KIND_IDENT;
      case (n)
         3'd2: begin
            if (p[15:0] == "if") k = KW_IF;
         end
         3'd3: begin
            if (p[23:0] == "i32") k = KW_I32;
            else if (p[23:0] == "i64") k = KW_I64;
            else if (p[23:0] == "f32") k = KW_F32;
            else if (p[23:0] == "f64") k = KW_F64;
            else if (p[23:0] == "for") k = KW_FOR;
         end
         3'd4: begin
            if (p[31:0] == "true") k = KW_TRUE;
            else if (p[31:0] == "else") k = KW_ELSE;
            else if (p[31:0] == "bool") k = KW_BOOL;
            else if (p[31:0] == "void") k = KW_VOID;
            else if (p[31:0] == "char") k = KW_CHAR;
         end
         3'd5: begin
            if (p[39:0] == "false") k = KW_FALSE;
            else if (p[39:0] == "print") k = KW_PRINT;
            else if (p[39:0] == "while") k = KW_WHILE;
         end
         3'd6: begin
            if (p[47:0] == "struct") k = KW_STRUCT;
            else if (p[47:0] == "sizeof") k = KW_SIZEOF;
            else if (p[47:0] == "return") k = KW_RETURN;
         end
         default: k = KIND_IDENT;
      endcase
      return k;
   endfunction

   // Returns {hit, kind} for a single-byte punctuator.
   function automatic logic [6:0] punct_kind(input logic [7:0] c);
      logic [6:0] r;
      case (c)
         "+": r = {1'b1, KIND_PLUS};
         "-": r = {1'b1, KIND_MINUS};
         "*": r = {1'b1, KIND_STAR};
         "/": r = {1'b1, KIND_SLASH};
         "(": r = {1'b1, KIND_LPAREN};
         ")": r = {1'b1, KIND_RPAREN};
         "=": r = {1'b1, KIND_ASSIGN};
         ";": r = {1'b1, KIND_SEMI};
         "{": r = {1'b1, KIND_LBRACE};
         "}": r = {1'b1, KIND_RBRACE};
         ",": r = {1'b1, KIND_COMMA};
         "&": r = {1'b1, KIND_AMP};
         ".": r = {1'b1, KIND_DOT};
         "[": r = {1'b1, KIND_LBRACK};
         "]": r = {1'b1, KIND_RBRACK};
         "!": r = {1'b1, KIND_BANG};
         default: r = {1'b0, KIND_ERROR};
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/stl_front.sv -----
`default_nettype none
module stl_front #(
   parameter int OFFSET_BITS = stl_pkg::DEF_OFFSET_BITS,
   parameter int LENGTH_BITS = stl_pkg::DEF_LENGTH_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 push,
   input  wire logic                                 full,
   input  wire logic [7:0]                           req_text_byte,
   input  wire logic                                 req_end_of_text,
   output stl_pkg::tok_ctl_type                      ctl,
   output logic [2:0][OFFSET_BITS-1:0]               tok_start,
   output logic [2:0][LENGTH_BITS-1:0]               tok_len,
   output logic [stl_pkg::LINE_BITS-1:0]             tok_line
);

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

   stl_pkg::scan_mode_type mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in, offset_ff, offset_in;
   logic [stl_pkg::LINE_BITS-1:0] line_ff, line_in, line_inc;
   logic [LENGTH_BITS-1:0] run_ff, run_in, run_inc, numdot_len;
   logic [47:0] prefix_ff, prefix_in;

   logic [7:0] c;
   logic accept, is_dig, is_alp, is_nl, is_blank, esc_ok, rescan, run_idle, starts_multi;
   logic [6:0] pun;
   logic [2:0] short_n;
   logic [5:0] id_kind;
   logic e0_v, e1_v, e2_v;
   logic [5:0] e0_k, e1_k, e2_k;
   logic [OFFSET_BITS-1:0] e0_s, e1_s, e2_s;
   logic [LENGTH_BITS-1:0] e0_l, e1_l, e2_l;

   assign c        = req_text_byte;
   assign accept   = push & ~full;
   assign is_dig   = (c >= "0") && (c <= "9");
   assign is_alp   = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
   assign is_nl    = (c == 8'h0A);
   assign is_blank = (c == " ") || (c == 8'h09) || (c == 8'h0D);
   assign esc_ok   = (c == "n") || (c == "t") || (c == "\\") || (c == "'");
   assign pun      = stl_pkg::punct_kind(c);
   assign starts_multi = is_dig || is_alp || (c == "-") || (c == "/") || (c == "\"")
                      || (c == "'");
   assign run_inc  = (run_ff == LEN_MAX) ? run_ff : run_ff + LENGTH_BITS'(1);
   assign line_inc = (line_ff == stl_pkg::LINE_MAX) ? line_ff
                   : line_ff + stl_pkg::LINE_BITS'(1);
   assign numdot_len = (run_ff == LEN_MAX) ? run_ff : run_ff - LENGTH_BITS'(1);
   assign short_n  = (run_ff != '0 && run_ff <= LENGTH_BITS'(6)) ? run_ff[2:0] : 3'd0;
   assign id_kind  = stl_pkg::ident_kind(prefix_ff, short_n);

   // A byte that ends the pending token is scanned again from the idle mode.
   always_comb begin
      case (mode_ff)
         stl_pkg::MODE_IDENT:   rescan = !(is_alp || is_dig);
         stl_pkg::MODE_INT:     rescan = !(is_dig || c == ".");
         stl_pkg::MODE_INT_DOT,
         stl_pkg::MODE_FRAC,
         stl_pkg::MODE_MINUS:   rescan = !is_dig;
         stl_pkg::MODE_SLASH:   rescan = !(c == "/" || c == "*");
         stl_pkg::MODE_LINE:    rescan = is_nl;
         stl_pkg::MODE_CH_ESC:  rescan = !esc_ok;
         default:               rescan = 1'b0;
      endcase
   end

   assign run_idle = (mode_ff == stl_pkg::MODE_IDLE) || rescan;

   // Next state.
   always_comb begin
      mode_in   = mode_ff;
      start_in  = start_ff;
      offset_in = offset_ff;
      line_in   = line_ff;
      run_in    = run_ff;
      prefix_in = prefix_ff;
      if (req_end_of_text) begin
         mode_in   = stl_pkg::MODE_IDLE;
         start_in  = '0;
         offset_in = '0;
         line_in   = stl_pkg::LINE_BITS'(1);
         run_in    = '0;
         prefix_in = '0;
      end else begin
         offset_in = offset_ff + OFFSET_BITS'(1);
         if (rescan) begin
            mode_in = stl_pkg::MODE_IDLE;
         end else begin
            case (mode_ff)
               stl_pkg::MODE_IDENT: begin
                  if (run_ff < LENGTH_BITS'(7)) prefix_in = {prefix_ff[39:0], c};
                  run_in = run_inc;
               end
               stl_pkg::MODE_INT: begin
                  run_in = run_inc;
                  if (c == ".") mode_in = stl_pkg::MODE_INT_DOT;
               end
               stl_pkg::MODE_INT_DOT: begin
                  run_in  = run_inc;
                  mode_in = stl_pkg::MODE_FRAC;
               end
               stl_pkg::MODE_FRAC: run_in = run_inc;
               stl_pkg::MODE_MINUS: begin
                  run_in  = run_inc;
                  mode_in = stl_pkg::MODE_INT;
               end
               stl_pkg::MODE_SLASH: begin
                  run_in  = run_inc;
                  mode_in = (c == "/") ? stl_pkg::MODE_LINE : stl_pkg::MODE_BLOCK;
               end
               stl_pkg::MODE_BLOCK: begin
                  run_in = run_inc;
                  if (c == "*") mode_in = stl_pkg::MODE_STAR;
                  else if (is_nl) line_in = line_inc;
               end
               stl_pkg::MODE_STAR: begin
                  run_in = run_inc;
                  if (c == "/") mode_in = stl_pkg::MODE_IDLE;
                  else if (is_nl) begin
                     line_in = line_inc;
                     mode_in = stl_pkg::MODE_BLOCK;
                  end else if (c != "*") mode_in = stl_pkg::MODE_BLOCK;
               end
               stl_pkg::MODE_STRING: begin
                  run_in = run_inc;
                  if (c == "\"") mode_in = stl_pkg::MODE_IDLE;
                  else if (is_nl) line_in = line_inc;
               end
               stl_pkg::MODE_CH_OPEN: begin
                  run_in  = run_inc;
                  mode_in = (c == "\\") ? stl_pkg::MODE_CH_ESC : stl_pkg::MODE_CH_CLOSE;
               end
               stl_pkg::MODE_CH_ESC: begin
                  run_in  = run_inc;
                  mode_in = stl_pkg::MODE_CH_CLOSE;
               end
               stl_pkg::MODE_CH_CLOSE: begin
                  run_in  = run_inc;
                  mode_in = stl_pkg::MODE_IDLE;
               end
               default: mode_in = mode_ff;
            endcase
         end
         if (run_idle) begin
            if (is_nl) begin
               line_in = line_inc;
            end else if (!is_blank) begin
               start_in  = offset_ff;
               run_in    = LENGTH_BITS'(1);
               prefix_in = is_alp ? {40'd0, c} : 48'd0;
               if (is_dig) mode_in = stl_pkg::MODE_INT;
               else if (is_alp) mode_in = stl_pkg::MODE_IDENT;
               else if (c == "-") mode_in = stl_pkg::MODE_MINUS;
               else if (c == "/") mode_in = stl_pkg::MODE_SLASH;
               else if (c == "\"") mode_in = stl_pkg::MODE_STRING;
               else if (c == "'") mode_in = stl_pkg::MODE_CH_OPEN;
               else mode_in = stl_pkg::MODE_IDLE;
            end
         end
      end
   end

   // Tokens produced by this item: e0 and e1 close the pending token, e2 is
   // a token of the byte itself or the end token.
   always_comb begin
      e0_v = 1'b0; e0_k = stl_pkg::KIND_ERROR; e0_s = start_ff; e0_l = run_ff;
      e1_v = 1'b0; e1_k = stl_pkg::KIND_DOT;   e1_s = offset_ff - OFFSET_BITS'(1);
      e1_l = LENGTH_BITS'(1);
      e2_v = 1'b0; e2_k = stl_pkg::KIND_END;   e2_s = offset_ff; e2_l = '0;
      if (req_end_of_text || rescan) begin
         case (mode_ff)
            stl_pkg::MODE_IDENT: begin e0_v = 1'b1; e0_k = id_kind; end
            stl_pkg::MODE_INT,
            stl_pkg::MODE_FRAC:  begin e0_v = 1'b1; e0_k = stl_pkg::KIND_NUMBER; end
            stl_pkg::MODE_INT_DOT: begin
               e0_v = 1'b1; e0_k = stl_pkg::KIND_NUMBER; e0_l = numdot_len;
               e1_v = 1'b1;
            end
            stl_pkg::MODE_MINUS: begin e0_v = 1'b1; e0_k = stl_pkg::KIND_MINUS; end
            stl_pkg::MODE_SLASH: begin e0_v = 1'b1; e0_k = stl_pkg::KIND_SLASH; end
            stl_pkg::MODE_BLOCK, stl_pkg::MODE_STAR, stl_pkg::MODE_STRING,
            stl_pkg::MODE_CH_OPEN, stl_pkg::MODE_CH_ESC, stl_pkg::MODE_CH_CLOSE:
               e0_v = 1'b1;
            default: e0_v = 1'b0;
         endcase
      end else if (mode_ff == stl_pkg::MODE_STRING && c == "\"") begin
         e0_v = 1'b1; e0_k = stl_pkg::KIND_STRING; e0_l = run_inc;
      end else if (mode_ff == stl_pkg::MODE_CH_CLOSE) begin
         e0_v = 1'b1; e0_k = stl_pkg::KIND_CHAR; e0_l = run_inc;
      end
      if (req_end_of_text) begin
         e2_v = 1'b1;
      end else if (run_idle && !is_nl && !is_blank && !starts_multi) begin
         e2_v = 1'b1;
         e2_k = pun[6] ? pun[5:0] : stl_pkg::KIND_ERROR;
         e2_l = LENGTH_BITS'(1);
      end
   end

   always_comb begin
      ctl.count   = 2'(e0_v) + 2'(e1_v) + 2'(e2_v);
      ctl.push    = accept && (ctl.count != 2'd0);
      ctl.kind[0] = e0_v ? e0_k : e2_k;
      tok_start[0] = e0_v ? e0_s : e2_s;
      tok_len[0]   = e0_v ? e0_l : e2_l;
      ctl.kind[1] = e1_v ? e1_k : e2_k;
      tok_start[1] = e1_v ? e1_s : e2_s;
      tok_len[1]   = e1_v ? e1_l : e2_l;
      ctl.kind[2] = e2_k;
      tok_start[2] = e2_s;
      tok_len[2]   = e2_l;
      tok_line    = line_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= stl_pkg::MODE_IDLE;
         start_ff  <= '0;
         offset_ff <= '0;
         line_ff   <= stl_pkg::LINE_BITS'(1);
         run_ff    <= '0;
         prefix_ff <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         start_ff  <= start_in;
         offset_ff <= offset_in;
         line_ff   <= line_in;
         run_ff    <= run_in;
         prefix_ff <= prefix_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/stl_back.sv -----
`default_nettype none
module stl_back #(
   parameter int OFFSET_BITS = stl_pkg::DEF_OFFSET_BITS,
   parameter int LENGTH_BITS = stl_pkg::DEF_LENGTH_BITS
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  stl_pkg::tok_ctl_type                      ctl,
   input  wire logic [2:0][OFFSET_BITS-1:0]          tok_start,
   input  wire logic [2:0][LENGTH_BITS-1:0]          tok_len,
   input  wire logic [stl_pkg::LINE_BITS-1:0]        tok_line,
   output logic                                      full,
   output logic                                      empty,
   input  wire logic                                 pop,
   output logic [5:0]                                rsp_token_kind,
   output logic [OFFSET_BITS-1:0]                    rsp_start_offset,
   output logic [LENGTH_BITS-1:0]                    rsp_token_length,
   output logic [stl_pkg::LINE_BITS-1:0]             rsp_line_number,
   output logic                                      rsp_final_token
);

   localparam int PB = stl_pkg::PTR_BITS;

   // Each entry holds all tokens of one item.
   logic [2:0][5:0]                  kind_mem  [stl_pkg::QUEUE_DEPTH];
   logic [2:0][OFFSET_BITS-1:0]      start_mem [stl_pkg::QUEUE_DEPTH];
   logic [2:0][LENGTH_BITS-1:0]      len_mem   [stl_pkg::QUEUE_DEPTH];
   logic [stl_pkg::LINE_BITS-1:0]    line_mem  [stl_pkg::QUEUE_DEPTH];
   logic [1:0]                       cnt_mem   [stl_pkg::QUEUE_DEPTH];

   logic [PB-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PB:0]   fill_ff, fill_in;
   logic [1:0]    sub_ff, sub_in;
   logic          do_pop, last, head_done;

   assign full  = (fill_ff == (PB+1)'(stl_pkg::QUEUE_DEPTH));
   assign empty = (fill_ff == '0);
   assign last  = (sub_ff == cnt_mem[rd_ff] - 2'd1);
   assign do_pop    = pop & ~empty;
   assign head_done = do_pop & last;

   assign rsp_token_kind   = kind_mem[rd_ff][sub_ff];
   assign rsp_start_offset = start_mem[rd_ff][sub_ff];
   assign rsp_token_length = len_mem[rd_ff][sub_ff];
   assign rsp_line_number  = line_mem[rd_ff];
   assign rsp_final_token  = last;

   always_comb begin
      wr_in   = ctl.push ? wr_ff + PB'(1) : wr_ff;
      rd_in   = head_done ? rd_ff + PB'(1) : rd_ff;
      sub_in  = head_done ? 2'd0 : (do_pop ? sub_ff + 2'd1 : sub_ff);
      fill_in = fill_ff + (PB+1)'(ctl.push) - (PB+1)'(head_done);
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         kind_mem[wr_ff]  <= ctl.kind;
         start_mem[wr_ff] <= tok_start;
         len_mem[wr_ff]   <= tok_len;
         line_mem[wr_ff]  <= tok_line;
         cnt_mem[wr_ff]   <= ctl.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
         sub_ff  <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
         sub_ff  <= sub_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/source_token_lexer.sv -----
`default_nettype none
// Streaming lexer: one source byte is taken per cycle whenever full is low,
// also while earlier tokens still wait at the output. The scanner state
// machine classifies each byte and hands the up to three tokens that the
// byte produces to a four-entry queue; tokens then leave one per cycle while
// pop is high, so a sustained byte rate of one per cycle holds while the text
// yields at most one token per byte, and the output port sets the pace
// otherwise. A token is usually reported with the byte that follows it.
module source_token_lexer #(
   parameter int OFFSET_BITS = stl_pkg::DEF_OFFSET_BITS,
   parameter int LENGTH_BITS = stl_pkg::DEF_LENGTH_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   output logic                               full,
   input  wire logic [7:0]                    req_text_byte,
   input  wire logic                          req_end_of_text,
   output logic                               empty,
   input  wire logic                          pop,
   output logic [5:0]                         rsp_token_kind,
   output logic [OFFSET_BITS-1:0]             rsp_start_offset,
   output logic [LENGTH_BITS-1:0]             rsp_token_length,
   output logic [stl_pkg::LINE_BITS-1:0]      rsp_line_number,
   output logic                               rsp_final_token
);

   stl_pkg::tok_ctl_type              ctl;
   logic [2:0][OFFSET_BITS-1:0]       tok_start;
   logic [2:0][LENGTH_BITS-1:0]       tok_len;
   logic [stl_pkg::LINE_BITS-1:0]     tok_line;

   stl_front #(.OFFSET_BITS(OFFSET_BITS), .LENGTH_BITS(LENGTH_BITS)) u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_text_byte(req_text_byte), .req_end_of_text(req_end_of_text),
      .ctl(ctl), .tok_start(tok_start), .tok_len(tok_len), .tok_line(tok_line)
   );

   stl_back #(.OFFSET_BITS(OFFSET_BITS), .LENGTH_BITS(LENGTH_BITS)) u_back (
      .clock(clock), .reset(reset), .ctl(ctl), .tok_start(tok_start),
      .tok_len(tok_len), .tok_line(tok_line), .full(full), .empty(empty),
      .pop(pop), .rsp_token_kind(rsp_token_kind), .rsp_start_offset(rsp_start_offset),
      .rsp_token_length(rsp_token_length), .rsp_line_number(rsp_line_number),
      .rsp_final_token(rsp_final_token)
   );

endmodule
`default_nettype wire

// ----- rtl/stl_checker.sv -----
`default_nettype none
module stl_checker #(
   parameter int OFFSET_BITS = stl_pkg::DEF_OFFSET_BITS,
   parameter int LENGTH_BITS = stl_pkg::DEF_LENGTH_BITS
) (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      full,
   input wire logic                      empty,
   input wire logic                      pop,
   input wire logic [5:0]                rsp_token_kind,
   input wire logic [OFFSET_BITS-1:0]    rsp_start_offset,
   input wire logic [LENGTH_BITS-1:0]    rsp_token_length,
   input wire logic                      rsp_final_token
);

   a_reset_empties: assert property (@(posedge clock) reset |=> empty)
      else $error("queue not empty after reset");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      !(full && empty))
      else $error("queue full and empty at once");

   a_held_item: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_token_kind)
                            && $stable(rsp_start_offset)))
      else $error("waiting item changed");

   // The end token is always the last of its item and has no length.
   a_end_token: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_token_kind == stl_pkg::KIND_END)
         |-> (rsp_final_token && rsp_token_length == '0))
      else $error("malformed end token");

endmodule

bind source_token_lexer stl_checker #(
   .OFFSET_BITS(OFFSET_BITS), .LENGTH_BITS(LENGTH_BITS)
) u_stl_checker (
   .clock(clock), .reset(reset), .full(full), .empty(empty), .pop(pop),
   .rsp_token_kind(rsp_token_kind), .rsp_start_offset(rsp_start_offset),
   .rsp_token_length(rsp_token_length), .rsp_final_token(rsp_final_token)
);
`default_nettype wire
